FILE: hw/rtl/qcpm_pkg.sv
// Shared types and constants for the quad cascaded PID mixer.
// Used by qcpm_smul and quad_cascaded_pid_mixer; no dependencies.
`default_nettype none

package qcpm_pkg;

    // Gain registers: unsigned Q8.16
    localparam int GAIN_W   = 24;
    // Multiplier operand: signed, wide enough for the rate loop error
    localparam int MUL_OPW  = 34;
    // Full product of unsigned gain by signed operand
    localparam int MUL_PW   = GAIN_W + MUL_OPW;
    // Gain digit consumed per cycle, most significant digit first
    localparam int DIGIT_W  = 8;
    localparam int DIGITS   = GAIN_W / DIGIT_W;
    localparam int DCNT_W   = $clog2(DIGITS);

    typedef struct packed {
        logic                      start;
        logic [GAIN_W-1:0]         gain;
        logic signed [MUL_OPW-1:0] operand;
    } qcpm_mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MUL_PW-1:0] product;
    } qcpm_mul_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/quad_cascaded_pid_mixer.sv
// Quad-X cascaded PID controller top level: sequencer, loop state and motor mixer.
// Depends on qcpm_pkg and qcpm_smul.
//
// Usage:
//  - s_* channel: one transaction per control tick (setpoints, measurements,
//    gyro, altitude, throttle, mode flags). s_ready is high only while the
//    controller is idle, so one tick is in work at a time.
//  - m_* channel: four motor commands per tick, held in an output register;
//    a new tick is taken while the previous result still waits there.
//  - cfg_* channel: gain writes by index, always ready; write only when idle.
// Sequence: 18 gain products run through one 8-bit digit-serial multiplier,
//  then the mixer forms the four motor commands in turn, and the output
//  register takes them and raises m_valid; only then is the next tick taken.
// A stalled receiver holds the result; the next tick finishes its work and
//  waits until the output register is free.
// Reset (aresetn low, synchronous): gains take their defaults, integrators,
//  gyro and altitude history clear, the hold target is recaptured on the next
//  tick with hold enabled, and m_valid drops.
`default_nettype none

module quad_cascaded_pid_mixer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // tick input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [16:0] s_set_roll,
    input  wire logic signed [16:0] s_set_pitch,
    input  wire logic signed [16:0] s_set_yaw,
    input  wire logic signed [16:0] s_meas_roll,
    input  wire logic signed [16:0] s_meas_pitch,
    input  wire logic signed [16:0] s_meas_yaw,
    input  wire logic signed [15:0] s_gyro_x,
    input  wire logic signed [15:0] s_gyro_y,
    input  wire logic signed [15:0] s_gyro_z,
    input  wire logic signed [23:0] s_altitude,
    input  wire logic signed [16:0] s_base_throttle,
    input  wire logic [1:0]         s_mode_flags,
    // motor output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_motor_front_a,
    output logic [15:0]             m_motor_rear_a,
    output logic [15:0]             m_motor_rear_b,
    output logic [15:0]             m_motor_front_b,
    // gain writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [qcpm_pkg::GAIN_W-1:0] cfg_data
);
    import qcpm_pkg::*;

    localparam int ACC_W   = 46;
    localparam int LOOP_W  = 37;
    localparam int MIX_W   = 41;
    localparam int INTEG_W = 14;
    localparam logic signed [ACC_W-1:0] INTEG_LIM = ACC_W'(30 * 256);
    localparam logic signed [ACC_W-1:0] LOOP_SAT  = (ACC_W'(1) <<< 36) - ACC_W'(1);
    localparam logic signed [24:0]      HOLD_LIM  = 25'sd500;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_MIX, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_AKP_R, OP_AKI_R, OP_AKD_R,
        OP_AKP_P, OP_AKI_P, OP_AKD_P,
        OP_AKP_Y, OP_AKD_Y,
        OP_RKP_R, OP_RKD_R, OP_RKI_R,
        OP_RKP_P, OP_RKD_P, OP_RKI_P,
        OP_RKP_Y, OP_RKD_Y,
        OP_HKP, OP_HKD
    } op_t;

    typedef enum logic [2:0] {
        CFG_ANGLE_KP, CFG_ANGLE_KI, CFG_ANGLE_KD, CFG_RATE_KP,
        CFG_RATE_KI, CFG_RATE_KD, CFG_HEIGHT_KP, CFG_HEIGHT_KD
    } cfg_idx_t;

    // gains
    logic [GAIN_W-1:0] angle_kp_reg, angle_ki_reg, angle_kd_reg;
    logic [GAIN_W-1:0] rate_kp_reg, rate_ki_reg, rate_kd_reg;
    logic [GAIN_W-1:0] height_kp_reg, height_kd_reg;

    // loop state
    logic signed [INTEG_W-1:0] oir_reg, oip_reg, iir_reg, iip_reg;
    logic signed [15:0]        prev_gx_reg, prev_gy_reg, prev_gz_reg;
    logic signed [23:0]        hold_target_reg, prev_alt_reg;
    logic                      pending_reg;

    // latched tick
    logic signed [17:0] e_roll_reg, e_pitch_reg, e_yaw_reg;
    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic signed [16:0] dgx_reg, dgy_reg, dgz_reg;
    logic signed [24:0] herr_reg, dalt_reg;
    logic signed [16:0] thr_reg;
    logic               armed_reg, hact_reg;

    // intermediate loop outputs
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [MUL_OPW-1:0] o_roll_reg, o_pitch_reg, o_yaw_reg;
    logic signed [LOOP_W-1:0]  r_roll_reg, r_pitch_reg, r_yaw_reg, h_reg;

    // sequencer and output
    state_t      state_reg;
    op_t         op_reg;
    logic [1:0]  mix_idx_reg;
    logic [15:0] mix_res_reg [4];
    logic        m_valid_reg;
    logic [15:0] motor_fa_reg, motor_ra_reg, motor_rb_reg, motor_fb_reg;

    qcpm_mul_req_t mul_req;
    qcpm_mul_rsp_t mul_rsp;

    // gyro counts to deg/s in Q.8: g * 4000 / 256, floored
    function automatic logic signed [19:0] gyro_dps(input logic signed [15:0] g);
        logic signed [27:0] gw;
        logic signed [27:0] x;
        gw = 28'(g);
        x  = (gw <<< 12) - (gw <<< 6) - (gw <<< 5);
        return 20'(x >>> 8);
    endfunction

    // accept-time values
    logic signed [17:0] e_roll_in, e_pitch_in, e_yaw_in;
    logic signed [23:0] tgt_in;
    logic signed [24:0] herr_in;
    logic               inb_in;

    assign e_roll_in  = 18'(s_set_roll)  + 18'(s_meas_roll);
    assign e_pitch_in = 18'(s_set_pitch) + 18'(s_meas_pitch);
    assign e_yaw_in   = 18'(s_set_yaw)   + 18'(s_meas_yaw);
    assign tgt_in     = pending_reg ? s_altitude : hold_target_reg;
    assign herr_in    = 25'(tgt_in) - 25'(s_altitude);
    assign inb_in     = (herr_in <= HOLD_LIM) && (herr_in >= -HOLD_LIM);

    // operation decode
    logic [GAIN_W-1:0]         op_gain;
    logic signed [MUL_OPW-1:0] op_operand;
    logic                      op_sh16, op_first, op_sub, op_integ;
    logic signed [INTEG_W-1:0] integ_cur;

    always_comb begin
        op_gain    = '0;
        op_operand = '0;
        op_sh16    = 1'b1;
        op_first   = 1'b0;
        op_sub     = 1'b0;
        op_integ   = 1'b0;
        integ_cur  = '0;
        unique case (op_reg)
            OP_AKP_R: begin
                op_gain = angle_kp_reg; op_operand = MUL_OPW'(e_roll_reg); op_first = 1'b1;
            end
            OP_AKI_R: begin
                op_gain = angle_ki_reg; op_operand = MUL_OPW'(e_roll_reg);
                op_integ = 1'b1; integ_cur = oir_reg;
            end
            OP_AKD_R: begin
                op_gain = angle_kd_reg; op_operand = MUL_OPW'(gy_reg); op_sh16 = 1'b0;
            end
            OP_AKP_P: begin
                op_gain = angle_kp_reg; op_operand = MUL_OPW'(e_pitch_reg); op_first = 1'b1;
            end
            OP_AKI_P: begin
                op_gain = angle_ki_reg; op_operand = MUL_OPW'(e_pitch_reg);
                op_integ = 1'b1; integ_cur = oip_reg;
            end
            OP_AKD_P: begin
                op_gain = angle_kd_reg; op_operand = MUL_OPW'(gx_reg); op_sh16 = 1'b0;
            end
            OP_AKP_Y: begin
                op_gain = angle_kp_reg; op_operand = MUL_OPW'(e_yaw_reg); op_first = 1'b1;
            end
            OP_AKD_Y: begin
                op_gain = angle_kd_reg; op_operand = MUL_OPW'(gz_reg); op_sh16 = 1'b0;
            end
            OP_RKP_R: begin
                op_gain = rate_kp_reg; op_first = 1'b1;
                op_operand = o_roll_reg + MUL_OPW'(gyro_dps(gy_reg));
            end
            OP_RKD_R: begin
                op_gain = rate_kd_reg; op_operand = MUL_OPW'(dgy_reg); op_sh16 = 1'b0;
            end
            OP_RKI_R: begin
                op_gain = rate_ki_reg; op_integ = 1'b1; integ_cur = iir_reg;
                op_operand = o_roll_reg + MUL_OPW'(gyro_dps(gy_reg));
            end
            OP_RKP_P: begin
                op_gain = rate_kp_reg; op_first = 1'b1;
                op_operand = o_pitch_reg + MUL_OPW'(gyro_dps(gx_reg));
            end
            OP_RKD_P: begin
                op_gain = rate_kd_reg; op_operand = MUL_OPW'(dgx_reg); op_sh16 = 1'b0;
            end
            OP_RKI_P: begin
                op_gain = rate_ki_reg; op_integ = 1'b1; integ_cur = iip_reg;
                op_operand = o_pitch_reg + MUL_OPW'(gyro_dps(gx_reg));
            end
            OP_RKP_Y: begin
                op_gain = rate_kp_reg; op_first = 1'b1;
                op_operand = o_yaw_reg + MUL_OPW'(gyro_dps(gz_reg));
            end
            OP_RKD_Y: begin
                op_gain = rate_kd_reg; op_operand = MUL_OPW'(dgz_reg); op_sh16 = 1'b0;
            end
            OP_HKP: begin
                op_gain = height_kp_reg; op_operand = MUL_OPW'(herr_reg);
                op_sh16 = 1'b0; op_first = 1'b1;
            end
            OP_HKD: begin
                op_gain = height_kd_reg; op_operand = MUL_OPW'(dalt_reg);
                op_sh16 = 1'b0; op_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign mul_req.start   = (state_reg == ST_ISSUE);
    assign mul_req.gain    = op_gain;
    assign mul_req.operand = op_operand;

    qcpm_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // floor-scale the product and fold it into the running loop sum
    logic signed [MUL_PW-1:0]  psh;
    logic signed [ACC_W-1:0]   term_p, integ_sum, term, acc_sum;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [LOOP_W-1:0]  acc_sat;

    assign psh       = op_sh16 ? (mul_rsp.product >>> 16) : (mul_rsp.product >>> 8);
    assign term_p    = psh[ACC_W-1:0];
    assign integ_sum = ACC_W'(integ_cur) + term_p;

    always_comb begin
        if (integ_sum > INTEG_LIM) begin
            integ_new = INTEG_W'(INTEG_LIM);
        end else if (integ_sum < -INTEG_LIM) begin
            integ_new = INTEG_W'(-INTEG_LIM);
        end else begin
            integ_new = integ_sum[INTEG_W-1:0];
        end
    end

    assign term    = op_integ ? ACC_W'(integ_new) : (op_sub ? -term_p : term_p);
    assign acc_sum = (op_first ? '0 : acc_reg) + term;

    always_comb begin
        if (acc_sum > LOOP_SAT) begin
            acc_sat = LOOP_W'(LOOP_SAT);
        end else if (acc_sum < -LOOP_SAT) begin
            acc_sat = LOOP_W'(-LOOP_SAT);
        end else begin
            acc_sat = acc_sum[LOOP_W-1:0];
        end
    end

    // quad-X mixer, one motor per cycle
    logic signed [MIX_W-1:0] mix_t, mix_r, mix_p, mix_y, mix_sum;
    logic [15:0]             mix_motor;

    assign mix_t = (MIX_W'(thr_reg) <<< 8) + (hact_reg ? MIX_W'(h_reg) : '0);
    assign mix_r = MIX_W'(r_roll_reg);
    assign mix_p = MIX_W'(r_pitch_reg);
    assign mix_y = MIX_W'(r_yaw_reg);

    always_comb begin
        case (mix_idx_reg)
            2'd0:    mix_sum = mix_t - mix_r - mix_p - mix_y;
            2'd1:    mix_sum = mix_t - mix_r + mix_p + mix_y;
            2'd2:    mix_sum = mix_t + mix_r + mix_p - mix_y;
            default: mix_sum = mix_t + mix_r - mix_p + mix_y;
        endcase
        if (!armed_reg || mix_sum < 0) begin
            mix_motor = '0;
        end else if (|mix_sum[MIX_W-1:24]) begin
            mix_motor = 16'hFFFF;
        end else begin
            mix_motor = mix_sum[23:8];
        end
    end

    // sequencer, loop state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_AKP_R;
            mix_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
            angle_kp_reg    <= GAIN_W'(524288);
            angle_ki_reg    <= GAIN_W'(66);
            angle_kd_reg    <= '0;
            rate_kp_reg     <= GAIN_W'(131072);
            rate_ki_reg     <= GAIN_W'(66);
            rate_kd_reg     <= GAIN_W'(13107);
            height_kp_reg   <= GAIN_W'(131072);
            height_kd_reg   <= GAIN_W'(65536);
            oir_reg         <= '0;
            oip_reg         <= '0;
            iir_reg         <= '0;
            iip_reg         <= '0;
            prev_gx_reg     <= '0;
            prev_gy_reg     <= '0;
            prev_gz_reg     <= '0;
            hold_target_reg <= '0;
            prev_alt_reg    <= '0;
            pending_reg     <= 1'b1;
        end else begin
            // gain writes
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ANGLE_KP:  angle_kp_reg  <= cfg_data;
                    CFG_ANGLE_KI:  angle_ki_reg  <= cfg_data;
                    CFG_ANGLE_KD:  angle_kd_reg  <= cfg_data;
                    CFG_RATE_KP:   rate_kp_reg   <= cfg_data;
                    CFG_RATE_KI:   rate_ki_reg   <= cfg_data;
                    CFG_RATE_KD:   rate_kd_reg   <= cfg_data;
                    CFG_HEIGHT_KP: height_kp_reg <= cfg_data;
                    CFG_HEIGHT_KD: height_kd_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        e_roll_reg  <= e_roll_in;
                        e_pitch_reg <= e_pitch_in;
                        e_yaw_reg   <= e_yaw_in;
                        gx_reg      <= s_gyro_x;
                        gy_reg      <= s_gyro_y;
                        gz_reg      <= s_gyro_z;
                        dgx_reg     <= 17'(s_gyro_x) - 17'(prev_gx_reg);
                        dgy_reg     <= 17'(s_gyro_y) - 17'(prev_gy_reg);
                        dgz_reg     <= 17'(s_gyro_z) - 17'(prev_gz_reg);
                        prev_gx_reg <= s_gyro_x;
                        prev_gy_reg <= s_gyro_y;
                        prev_gz_reg <= s_gyro_z;
                        thr_reg     <= s_base_throttle;
                        armed_reg   <= s_mode_flags[0];
                        herr_reg    <= herr_in;
                        dalt_reg    <= 25'(s_altitude) - 25'(prev_alt_reg);
                        // altitude hold target capture
                        if (s_mode_flags[1]) begin
                            hold_target_reg <= tgt_in;
                            pending_reg     <= 1'b0;
                            hact_reg        <= inb_in;
                            if (inb_in) begin
                                prev_alt_reg <= s_altitude;
                            end
                        end else begin
                            pending_reg <= 1'b1;
                            hact_reg    <= 1'b0;
                        end
                        op_reg    <= OP_AKP_R;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_rsp.done) begin
                        acc_reg <= acc_sum;
                        case (op_reg)
                            OP_AKI_R: oir_reg     <= integ_new;
                            OP_AKI_P: oip_reg     <= integ_new;
                            OP_RKI_R: begin
                                iir_reg    <= integ_new;
                                r_roll_reg <= acc_sat;
                            end
                            OP_RKI_P: begin
                                iip_reg     <= integ_new;
                                r_pitch_reg <= acc_sat;
                            end
                            OP_AKD_R: o_roll_reg  <= acc_sum[MUL_OPW-1:0];
                            OP_AKD_P: o_pitch_reg <= acc_sum[MUL_OPW-1:0];
                            OP_AKD_Y: o_yaw_reg   <= acc_sum[MUL_OPW-1:0];
                            OP_RKD_Y: r_yaw_reg   <= acc_sat;
                            OP_HKD:   h_reg       <= acc_sat;
                            default: ;
                        endcase
                        if (op_reg == OP_HKD) begin
                            mix_idx_reg <= '0;
                            state_reg   <= ST_MIX;
                        end else begin
                            op_reg    <= op_t'(op_reg + 5'd1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_MIX: begin
                    mix_res_reg[mix_idx_reg] <= mix_motor;
                    mix_idx_reg              <= mix_idx_reg + 2'd1;
                    if (mix_idx_reg == 2'd3) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        motor_fa_reg <= mix_res_reg[0];
                        motor_ra_reg <= mix_res_reg[1];
                        motor_rb_reg <= mix_res_reg[2];
                        motor_fb_reg <= mix_res_reg[3];
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_motor_front_a = motor_fa_reg;
    assign m_motor_rear_a  = motor_ra_reg;
    assign m_motor_rear_b  = motor_rb_reg;
    assign m_motor_front_b = motor_fb_reg;

`ifndef ASSERT_OFF
    // one tick in flight: an accepted transaction closes the input
    a_single_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a tick is in work");

    // multiplier results only arrive while the sequencer waits for them
    a_mul_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> state_reg == ST_WAIT)
        else $error("multiplier result outside wait state");

    // the roll angle and pitch rate integrators stay inside their clamp
    a_integ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ACC_W'(oir_reg) <= INTEG_LIM && ACC_W'(oir_reg) >= -INTEG_LIM &&
        ACC_W'(iip_reg) <= INTEG_LIM && ACC_W'(iip_reg) >= -INTEG_LIM)
        else $error("integrator outside clamp");

    // a disarmed tick gives all-zero motors
    a_disarmed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && !armed_reg && (!m_valid_reg || m_ready) |=>
        m_motor_front_a == '0 && m_motor_rear_a == '0 &&
        m_motor_rear_b == '0 && m_motor_front_b == '0)
        else $error("motor command while disarmed");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/qcpm_smul.sv
// Digit-serial multiplier: unsigned gain times signed operand, one gain digit per cycle.
// Depends on qcpm_pkg.
`default_nettype none

module qcpm_smul (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire qcpm_pkg::qcpm_mul_req_t req,
    output qcpm_pkg::qcpm_mul_rsp_t      rsp
);
    import qcpm_pkg::*;

    logic [GAIN_W-1:0]           gain_sr_reg;
    logic signed [MUL_OPW-1:0]   opnd_reg;
    logic signed [MUL_PW-1:0]    acc_reg;
    logic [DCNT_W-1:0]           cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DIGIT_W-1:0]          digit;
    logic signed [MUL_OPW+DIGIT_W:0] pp;

    // top digit of the gain shift register times the operand
    assign digit = gain_sr_reg[GAIN_W-1 -: DIGIT_W];
    assign pp    = opnd_reg * $signed({1'b0, digit});

    // shift-and-add, MSB digit first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                gain_sr_reg <= req.gain;
                opnd_reg    <= req.operand;
                acc_reg     <= '0;
                cnt_reg     <= DCNT_W'(DIGITS - 1);
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                acc_reg     <= (acc_reg <<< DIGIT_W) + MUL_PW'(pp);
                gain_sr_reg <= gain_sr_reg << DIGIT_W;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

FILE: tb/sv/quad_cascaded_pid_mixer_tb.sv
// Self-checking testbench for quad_cascaded_pid_mixer: directed ticks, then random ticks
// under several gain settings, checked against a cycle-free model or, for some directed
// ticks, fixed values. Depends on qcpm_pkg and the quad_cascaded_pid_mixer RTL.
`timescale 1ns / 1ps

module quad_cascaded_pid_mixer_tb;
    import qcpm_pkg::*;

    // gain register indexes
    localparam logic [2:0] REG_ANGLE_KP  = 3'd0;
    localparam logic [2:0] REG_ANGLE_KI  = 3'd1;
    localparam logic [2:0] REG_ANGLE_KD  = 3'd2;
    localparam logic [2:0] REG_RATE_KP   = 3'd3;
    localparam logic [2:0] REG_RATE_KI   = 3'd4;
    localparam logic [2:0] REG_RATE_KD   = 3'd5;
    localparam logic [2:0] REG_HEIGHT_KP = 3'd6;
    localparam logic [2:0] REG_HEIGHT_KD = 3'd7;
    localparam int         NUM_REGS      = 8;

    localparam logic [1:0] FLAG_OFF   = 2'b00;
    localparam logic [1:0] FLAG_ARMED = 2'b01;
    localparam logic [1:0] FLAG_HOLD  = 2'b10;
    localparam logic [1:0] FLAG_BOTH  = 2'b11;

    localparam longint INTEG_LIM = 30 * 256;
    localparam longint HOLD_LIM  = 500;
    localparam longint LOOP_LIM  = (longint'(1) << 36) - 1;
    localparam longint GYRO_DPS  = 4000;
    localparam int     ANGLE_MAX = 46080;
    localparam int     TAIL_CYC  = 150;
    localparam int     RAND_PER_PHASE = 80;

    typedef struct {
        logic signed [16:0] set_r, set_p, set_y, meas_r, meas_p, meas_y;
        logic signed [15:0] gx, gy, gz;
        logic signed [23:0] alt;
        logic signed [16:0] thr;
        logic [1:0]         flags;
        bit                 typed;
        logic [15:0]        want[4];
    } tick_t;

    typedef struct {
        logic [15:0] m[4];
    } motors_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [16:0] s_set_roll = '0, s_set_pitch = '0, s_set_yaw = '0;
    logic signed [16:0] s_meas_roll = '0, s_meas_pitch = '0, s_meas_yaw = '0;
    logic signed [15:0] s_gyro_x = '0, s_gyro_y = '0, s_gyro_z = '0;
    logic signed [23:0] s_altitude = '0;
    logic signed [16:0] s_base_throttle = '0;
    logic [1:0]         s_mode_flags = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_motor_front_a, m_motor_rear_a, m_motor_rear_b, m_motor_front_b;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [GAIN_W-1:0] cfg_data = '0;

    quad_cascaded_pid_mixer DUT (.*);

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // model state
    logic [GAIN_W-1:0] gain[NUM_REGS];
    longint o_roll_i, o_pitch_i, i_roll_i, i_pitch_i;
    longint last_gyro[3];
    longint hold_alt, last_alt;
    bit     recapture;

    motors_t motor_fifo[$];
    int errors = 0;
    bit quiet = 0;
    int stall_left = 0;

    function automatic longint sat(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // gain times Q.8 signal, and gain times raw count
    function automatic longint gsig(logic [GAIN_W-1:0] g, longint v);
        return (longint'(g) * v) >>> 16;
    endfunction

    function automatic longint graw(logic [GAIN_W-1:0] g, longint v);
        return (longint'(g) * v) >>> 8;
    endfunction

    function automatic logic [15:0] motor_sat(longint q);
        longint m;
        m = q >>> 8;
        if (m < 0) return 16'd0;
        if (m > 65535) return 16'hFFFF;
        return m[15:0];
    endfunction

    function automatic void reset_model();
        gain[REG_ANGLE_KP] = 24'd524288;  gain[REG_ANGLE_KI] = 24'd66;
        gain[REG_ANGLE_KD] = 24'd0;       gain[REG_RATE_KP] = 24'd131072;
        gain[REG_RATE_KI] = 24'd66;       gain[REG_RATE_KD] = 24'd13107;
        gain[REG_HEIGHT_KP] = 24'd131072; gain[REG_HEIGHT_KD] = 24'd65536;
        o_roll_i = 0; o_pitch_i = 0; i_roll_i = 0; i_pitch_i = 0;
        last_gyro[0] = 0; last_gyro[1] = 0; last_gyro[2] = 0;
        hold_alt = 0; last_alt = 0; recapture = 1;
    endfunction

    // one control tick: cascaded loops, altitude hold, quad-X mix
    function automatic motors_t mix_predict(tick_t t);
        longint er, ep, ey, gx, gy, gz, alt, ro, po, yo, rr, pr, yr, h, herr, tq;
        motors_t r;
        er = longint'(t.set_r) + longint'(t.meas_r);
        ep = longint'(t.set_p) + longint'(t.meas_p);
        ey = longint'(t.set_y) + longint'(t.meas_y);
        gx = longint'(t.gx); gy = longint'(t.gy); gz = longint'(t.gz);
        alt = longint'(t.alt);

        o_roll_i = sat(o_roll_i + gsig(gain[REG_ANGLE_KI], er), INTEG_LIM);
        o_pitch_i = sat(o_pitch_i + gsig(gain[REG_ANGLE_KI], ep), INTEG_LIM);
        ro = sat(gsig(gain[REG_ANGLE_KP], er) + o_roll_i + graw(gain[REG_ANGLE_KD], gy),
                 LOOP_LIM);
        po = sat(gsig(gain[REG_ANGLE_KP], ep) + o_pitch_i + graw(gain[REG_ANGLE_KD], gx),
                 LOOP_LIM);
        yo = sat(gsig(gain[REG_ANGLE_KP], ey) + graw(gain[REG_ANGLE_KD], gz), LOOP_LIM);

        ro = ro + ((gy * GYRO_DPS) >>> 8);
        po = po + ((gx * GYRO_DPS) >>> 8);
        yo = yo + ((gz * GYRO_DPS) >>> 8);
        i_roll_i = sat(i_roll_i + gsig(gain[REG_RATE_KI], ro), INTEG_LIM);
        i_pitch_i = sat(i_pitch_i + gsig(gain[REG_RATE_KI], po), INTEG_LIM);
        rr = sat(gsig(gain[REG_RATE_KP], ro) + graw(gain[REG_RATE_KD], gy - last_gyro[1])
                 + i_roll_i, LOOP_LIM);
        pr = sat(gsig(gain[REG_RATE_KP], po) + graw(gain[REG_RATE_KD], gx - last_gyro[0])
                 + i_pitch_i, LOOP_LIM);
        yr = sat(gsig(gain[REG_RATE_KP], yo) + graw(gain[REG_RATE_KD], gz - last_gyro[2]),
                 LOOP_LIM);
        last_gyro[0] = gx; last_gyro[1] = gy; last_gyro[2] = gz;

        h = 0;
        if (t.flags & FLAG_HOLD) begin
            if (recapture) begin
                hold_alt = alt;
                recapture = 0;
            end
            herr = hold_alt - alt;
            if (herr <= HOLD_LIM && herr >= -HOLD_LIM) begin
                h = sat(graw(gain[REG_HEIGHT_KP], herr)
                        - graw(gain[REG_HEIGHT_KD], alt - last_alt), LOOP_LIM);
                last_alt = alt;
            end
        end else begin
            recapture = 1;
        end

        if (t.flags & FLAG_ARMED) begin
            tq = longint'(t.thr) * 256 + h;
            r.m[0] = motor_sat(tq - rr - pr - yr);
            r.m[1] = motor_sat(tq - rr + pr + yr);
            r.m[2] = motor_sat(tq + rr + pr - yr);
            r.m[3] = motor_sat(tq + rr - pr + yr);
        end else begin
            r.m[0] = '0; r.m[1] = '0; r.m[2] = '0; r.m[3] = '0;
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic tick_t row(int sr, int sp, int sy, int mr, int mp, int my,
                                  int gx, int gy, int gz, int alt, int thr,
                                  logic [1:0] fl, bit typed = 0, int w = 0);
        tick_t t;
        t.set_r = 17'(sr); t.set_p = 17'(sp); t.set_y = 17'(sy);
        t.meas_r = 17'(mr); t.meas_p = 17'(mp); t.meas_y = 17'(my);
        t.gx = 16'(gx); t.gy = 16'(gy); t.gz = 16'(gz);
        t.alt = 24'(alt); t.thr = 17'(thr); t.flags = fl;
        t.typed = typed;
        for (int i = 0; i < 4; i++) t.want[i] = 16'(w);
        return t;
    endfunction

    function automatic int rand_angle();
        return $urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX;
    endfunction

    // random tick: mostly armed hold with the altitude wandering near the target
    function automatic tick_t rand_tick(ref int alt_walk);
        tick_t t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) alt_walk = int'($urandom);
        else alt_walk = alt_walk + $urandom_range(0, 700) - 350;
        t = row(rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                rand_angle(), 0, 0, 0, alt_walk, $urandom_range(0, 98303) - 32768,
                (r < 75) ? FLAG_BOTH : 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 1)) begin
            t.gx = 16'($urandom); t.gy = 16'($urandom); t.gz = 16'($urandom);
        end else begin
            t.gx = 16'($urandom_range(0, 400) - 200);
            t.gy = 16'($urandom_range(0, 400) - 200);
            t.gz = 16'($urandom_range(0, 400) - 200);
        end
        return t;
    endfunction

    // drive one tick at the falling edge, predict on acceptance
    task automatic send_tick(input tick_t t);
        int g;
        motors_t p;
        g = gap_len();
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_set_roll <= t.set_r; s_set_pitch <= t.set_p; s_set_yaw <= t.set_y;
        s_meas_roll <= t.meas_r; s_meas_pitch <= t.meas_p; s_meas_yaw <= t.meas_y;
        s_gyro_x <= t.gx; s_gyro_y <= t.gy; s_gyro_z <= t.gz;
        s_altitude <= t.alt; s_base_throttle <= t.thr; s_mode_flags <= t.flags;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = mix_predict(t);
        if (t.typed) p.m = t.want;
        motor_fifo.push_back(p);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (motor_fifo.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [2:0] idx, input logic [GAIN_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        gain[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        motors_t w;
        if (aresetn && m_valid && m_ready) begin
            if (motor_fifo.size() == 0) begin
                $display("%0t: motor transaction with nothing pending", $realtime);
                errors++;
            end else begin
                w = motor_fifo.pop_front();
                if (m_motor_front_a !== w.m[0]) report("motor_front_a", m_motor_front_a, w.m[0]);
                if (m_motor_rear_a !== w.m[1]) report("motor_rear_a", m_motor_rear_a, w.m[1]);
                if (m_motor_rear_b !== w.m[2]) report("motor_rear_b", m_motor_rear_b, w.m[2]);
                if (m_motor_front_b !== w.m[3]) report("motor_front_b", m_motor_front_b, w.m[3]);
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
        end
    end

    initial begin
        #20ms;
        $display("quad_cascaded_pid_mixer_tb failed");
        $finish;
    end

    initial begin
        tick_t dir_tab[$];
        int alt_walk;
        logic [GAIN_W-1:0] gv;
        reset_model();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed ticks at default gains
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, FLAG_OFF, 1, 0));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100, FLAG_ARMED, 1, 100));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, FLAG_ARMED, 1, 65535));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -32768, FLAG_ARMED, 1, 0));
        dir_tab.push_back(row(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX,
                              ANGLE_MAX, 32767, 32767, 32767, 0, 65535, FLAG_OFF, 1, 0));
        dir_tab.push_back(row(-ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX,
                              -ANGLE_MAX, -32768, -32768, -32768, 0, 30000, FLAG_ARMED));
        dir_tab.push_back(row(ANGLE_MAX, -ANGLE_MAX, ANGLE_MAX, 0, 0, 0,
                              32767, -32768, 32767, 0, 30000, FLAG_ARMED));
        dir_tab.push_back(row(256, -256, 512, 0, 0, 0, 10, -10, 5, 1000, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1400, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1501, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 500, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 499, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 700, 20000, FLAG_ARMED));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, -8388608, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 8388607, 20000, FLAG_BOTH));
        dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, -8388400, 0, FLAG_HOLD, 1, 0));
        dir_tab.push_back(row(-ANGLE_MAX, 0, 0, ANGLE_MAX, 0, 0, 1, -1, 0, 0, 40000,
                              FLAG_BOTH));
        dir_tab.push_back(row(1, 1, 1, -1, -1, -1, 0, 0, 0, 0, 65535, FLAG_BOTH));
        foreach (dir_tab[i]) send_tick(dir_tab[i]);
        drain();

        // random ticks under several gain settings
        alt_walk = 0;
        for (int ph = 0; ph < 5; ph++) begin
            quiet = (ph == 2);
            for (int r = 0; r < NUM_REGS; r++) begin
                case (ph)
                    0: gv = gain[r];
                    1: gv = '1;
                    2: gv = '0;
                    3: gv = GAIN_W'($urandom);
                    default: gv = GAIN_W'($urandom_range(0, 1 << 18));
                endcase
                if (ph != 0) write_gain(3'(r), gv);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) send_tick(rand_tick(alt_walk));
            drain();
        end

        if (errors == 0) begin
            $display("quad_cascaded_pid_mixer_tb passed");
        end else begin
            $display("quad_cascaded_pid_mixer_tb failed");
        end
        $finish;
    end

endmodule

FILE: quad_cascaded_pid_mixer.f
hw/rtl/qcpm_pkg.sv
hw/rtl/qcpm_smul.sv
hw/rtl/quad_cascaded_pid_mixer.sv
tb/sv/quad_cascaded_pid_mixer_tb.sv
